### design/hla_pkg.sv
// Shared types and constants for the heap allocator.
package hla_pkg;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_FREE    = 2'd2;
    localparam logic [1:0] CMD_REALLOC = 2'd3;

    localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
    localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
    localparam logic [31:0] MIN_BLOCK = 32'd16;

    localparam logic [20:0] CHUNK_RESET = 21'd4096;
    localparam logic        REG_CHUNK   = 1'b0;

    // one heap memory access, byte addressed
    typedef struct packed {
        logic        we;
        logic [31:0] waddr;
        logic [31:0] wdata;
        logic        re;
        logic [31:0] raddr;
    } t_mem_req;

endpackage

### design/hla_if.sv
// Handshake channels for command items and result items.
interface hla_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [20:0] request_bytes;
    logic [19:0] block_address;
    modport source (output valid, command, request_bytes, block_address, input ready);
    modport sink (input valid, command, request_bytes, block_address, output ready);
endinterface

interface hla_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] result_address;
    logic        success;
    logic [20:0] copy_length;
    modport source (output valid, result_address, success, copy_length, input ready);
    modport sink (input valid, result_address, success, copy_length, output ready);
endinterface

### design/hla_heap_mem.sv
// Heap word memory, one write and one registered read per cycle.
module hla_heap_mem #(
    parameter int AW = 18
) (
    input  logic              i_clk,
    input  hla_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);
    import hla_pkg::*;

    logic [31:0] r_mem [2**AW];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW+1:2]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW+1:2]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/implicit_list_heap_allocator.sv
// Top level of the first-fit implicit free list heap allocator.
// Each command item runs to completion on a sequencer that reads, modifies
// and writes back header and footer words in one heap memory of HEAP_BYTES
// bytes (a power of two); every dependent word read goes through the memory's
// registered read port. Init writes the padding, prologue and epilogue words,
// then grows the heap by one chunk. Allocate walks the block headers first-fit,
// grows the heap and merges when no block fits, and splits the placed block
// when enough is left over. Free clears the allocated bit and merges with free
// neighbors; reallocate allocates, then frees the old block. A command rejected
// before any heap access goes straight to its result. One result item per
// command; the result sits in an output register so the next command is taken
// while it waits, and a stalled output holds the sequencer only once the next
// result is ready. chunk_bytes sits at byte address 0 of the register port and
// is to be written by the user only while idle; the block does not enforce it.
module implicit_list_heap_allocator #(
    parameter int HEAP_BYTES = 1048576
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hla_in_if.sink      in_ch,
    hla_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hla_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES) - 2;
    localparam int BW = $clog2(HEAP_BYTES) + 1;

    localparam logic [5:0] S_IDLE = 6'd0,  S_DONE = 6'd1,
        S_I0 = 6'd2,  S_I1 = 6'd3,  S_I2 = 6'd4,  S_I3 = 6'd5,
        S_G0 = 6'd6,  S_G1 = 6'd7,  S_G2 = 6'd8,
        S_M0 = 6'd9,  S_M1 = 6'd10, S_M2 = 6'd11, S_M3 = 6'd12,
        S_M4 = 6'd13, S_M5 = 6'd14, S_M6 = 6'd15,
        S_WA1 = 6'd16, S_WA2 = 6'd17,
        S_WB1 = 6'd18, S_WB2 = 6'd19, S_WB3 = 6'd20, S_WB4 = 6'd21, S_WB5 = 6'd22,
        S_WC1 = 6'd23, S_WC2 = 6'd24, S_WC3 = 6'd25, S_WC4 = 6'd26,
        S_WC5 = 6'd27, S_WC6 = 6'd28, S_WC7 = 6'd29,
        S_FS = 6'd30, S_F1 = 6'd31,
        S_P0 = 6'd32, S_P1 = 6'd33, S_P2 = 6'd34, S_P3 = 6'd35, S_P4 = 6'd36,
        S_PN2 = 6'd37,
        S_R0 = 6'd38, S_R1 = 6'd39,
        S_L0 = 6'd40, S_L1 = 6'd41, S_L2 = 6'd42;

    // control
    logic [5:0]    r_state, n_state;
    logic [BW-1:0] r_break, n_break;
    logic          r_inited, n_inited;
    logic          r_mrel, n_mrel;     // merge called from release
    logic [20:0]   r_chunk;
    logic          r_ovalid;

    // payload / work registers
    logic [1:0]  r_cmd, n_cmd;
    logic [20:0] r_req, n_req;
    logic [19:0] r_addr, n_addr;
    logic [31:0] r_bp, n_bp;
    logic [31:0] r_t, n_t;
    logic [31:0] r_sz, n_sz;
    logic [31:0] r_psz, n_psz;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_csz, n_csz;
    logic [31:0] r_asize, n_asize;
    logic [31:0] r_ext, n_ext;
    logic        r_pa, n_pa;
    logic [19:0] r_res, n_res;
    logic        r_ok, n_ok;
    logic [20:0] r_copy, n_copy;
    logic [19:0] r_ores;
    logic        r_ook;
    logic [20:0] r_ocopy;

    t_mem_req    mreq;
    logic [31:0] rd;
    logic [31:0] sz_rd;
    logic        m_done, pl_done;
    logic [31:0] m_ret;
    logic [21:0] chunk_rnd;
    logic [31:0] chunk_eff;
    logic [32:0] walk_nx;
    logic        out_load;
    logic        cfg_wr;

    hla_heap_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_req   (mreq),
        .o_rdata (rd)
    );

    assign sz_rd     = rd & SIZE_MASK;
    assign chunk_rnd = ({1'b0, r_chunk} + 22'd7) & 22'h3F_FFF8;
    assign chunk_eff = (chunk_rnd == 22'd0) ? 32'd8 : 32'(chunk_rnd);
    assign walk_nx   = {1'b0, r_bp} + {1'b0, sz_rd};

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CHUNK) ? {11'd0, r_chunk} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= CHUNK_RESET;
        end else if (cfg_wr && paddr[2] == REG_CHUNK) begin
            r_chunk <= pwdata[20:0];
        end
    end

    assign in_ch.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;  n_break = r_break;  n_inited = r_inited;
        n_mrel = r_mrel;    n_cmd = r_cmd;      n_req = r_req;
        n_addr = r_addr;    n_bp = r_bp;        n_t = r_t;
        n_sz = r_sz;        n_psz = r_psz;      n_sum = r_sum;
        n_csz = r_csz;      n_asize = r_asize;  n_ext = r_ext;
        n_pa = r_pa;        n_res = r_res;      n_ok = r_ok;
        n_copy = r_copy;
        mreq = '0;
        m_done = 1'b0;
        m_ret = r_bp;
        pl_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_ch.valid) begin
                    n_cmd  = in_ch.command;
                    n_req  = in_ch.request_bytes;
                    n_addr = in_ch.block_address;
                    n_res  = '0;
                    n_ok   = 1'b0;
                    n_copy = '0;
                    n_asize = (in_ch.request_bytes <= 21'd8) ? MIN_BLOCK
                            : ((32'(in_ch.request_bytes) + 32'd15) & SIZE_MASK);
                    if (in_ch.command == CMD_INIT) begin
                        n_state = S_I0;
                    end else if (!r_inited) begin
                        n_state = S_DONE;
                    end else if (in_ch.command == CMD_FREE) begin
                        n_bp = 32'(in_ch.block_address);
                        n_mrel = 1'b1;
                        n_state = S_L0;
                    end else if (in_ch.request_bytes == 21'd0) begin
                        n_state = S_DONE;
                    end else begin
                        n_mrel = 1'b0;
                        n_state = S_FS;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || out_ch.ready) begin
                    n_state = S_IDLE;
                end
            end
            // padding, prologue, epilogue
            S_I0: begin
                mreq.we = 1'b1; mreq.waddr = 32'd0; mreq.wdata = 32'd0;
                n_break = BW'(16);
                n_inited = 1'b1;
                n_state = S_I1;
            end
            S_I1: begin
                mreq.we = 1'b1; mreq.waddr = 32'd4; mreq.wdata = 32'd8 | ALLOC_BIT;
                n_state = S_I2;
            end
            S_I2: begin
                mreq.we = 1'b1; mreq.waddr = 32'd8; mreq.wdata = 32'd8 | ALLOC_BIT;
                n_state = S_I3;
            end
            S_I3: begin
                mreq.we = 1'b1; mreq.waddr = 32'd12; mreq.wdata = ALLOC_BIT;
                n_ext = chunk_eff;
                n_mrel = 1'b0;
                n_state = S_G0;
            end
            // grow heap by r_ext
            S_G0: begin
                if ({1'b0, 32'(r_break)} + {1'b0, r_ext} > 33'(HEAP_BYTES)) begin
                    n_ok = 1'b0;
                    n_res = '0;
                    n_state = S_DONE;
                end else begin
                    n_bp = 32'(r_break);
                    n_break = r_break + r_ext[BW-1:0];
                    mreq.we = 1'b1;
                    mreq.waddr = 32'(r_break) - 32'd4;
                    mreq.wdata = r_ext;
                    n_state = S_G1;
                end
            end
            S_G1: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_ext - 32'd8; mreq.wdata = r_ext;
                n_state = S_G2;
            end
            S_G2: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_ext - 32'd4; mreq.wdata = ALLOC_BIT;
                n_state = S_M0;
            end
            // merge: gather neighbor state
            S_M0: begin
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd8;
                n_state = S_M1;
            end
            S_M1: begin
                n_t = r_bp - sz_rd;
                mreq.re = 1'b1; mreq.raddr = r_bp - sz_rd - 32'd4;
                n_state = S_M2;
            end
            S_M2: begin
                n_psz = sz_rd;
                mreq.re = 1'b1; mreq.raddr = r_t + sz_rd - 32'd8;
                n_state = S_M3;
            end
            S_M3: begin
                n_pa = rd[0];
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd4;
                n_state = S_M4;
            end
            S_M4: begin
                n_sz = sz_rd;
                n_t = r_bp + sz_rd;
                mreq.re = 1'b1; mreq.raddr = r_bp + sz_rd - 32'd4;
                n_state = S_M5;
            end
            S_M5: begin
                case ({r_pa, rd[0]})
                    2'b11: begin
                        m_done = 1'b1;
                    end
                    2'b10: begin
                        n_sum = r_sz + sz_rd;
                        n_state = S_WA1;
                    end
                    2'b01: begin
                        n_sum = r_sz + r_psz;
                        n_state = S_WB1;
                    end
                    default: begin
                        mreq.re = 1'b1; mreq.raddr = r_t + sz_rd - 32'd8;
                        n_state = S_M6;
                    end
                endcase
            end
            S_M6: begin
                n_sum = r_sz + r_psz + sz_rd;
                n_state = S_WC1;
            end
            // next block free
            S_WA1: begin
                mreq.we = 1'b1; mreq.waddr = r_bp - 32'd4; mreq.wdata = r_sum;
                n_state = S_WA2;
            end
            S_WA2: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_sum - 32'd8; mreq.wdata = r_sum;
                m_done = 1'b1;
            end
            // previous block free; neighbors re-read after each write
            S_WB1: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_sz - 32'd8; mreq.wdata = r_sum;
                n_state = S_WB2;
            end
            S_WB2: begin
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd8;
                n_state = S_WB3;
            end
            S_WB3: begin
                mreq.we = 1'b1; mreq.waddr = r_bp - sz_rd - 32'd4; mreq.wdata = r_sum;
                n_state = S_WB4;
            end
            S_WB4: begin
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd8;
                n_state = S_WB5;
            end
            S_WB5: begin
                m_done = 1'b1;
                m_ret = r_bp - sz_rd;
            end
            // both neighbors free
            S_WC1: begin
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd8;
                n_state = S_WC2;
            end
            S_WC2: begin
                mreq.we = 1'b1; mreq.waddr = r_bp - sz_rd - 32'd4; mreq.wdata = r_sum;
                n_state = S_WC3;
            end
            S_WC3: begin
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd4;
                n_state = S_WC4;
            end
            S_WC4: begin
                n_t = r_bp + sz_rd;
                mreq.re = 1'b1; mreq.raddr = r_bp + sz_rd - 32'd4;
                n_state = S_WC5;
            end
            S_WC5: begin
                mreq.we = 1'b1; mreq.waddr = r_t + sz_rd - 32'd8; mreq.wdata = r_sum;
                n_state = S_WC6;
            end
            S_WC6: begin
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd8;
                n_state = S_WC7;
            end
            S_WC7: begin
                m_done = 1'b1;
                m_ret = r_bp - sz_rd;
            end
            // first-fit walk, one header per cycle
            S_FS: begin
                if (32'd8 >= 32'(r_break)) begin
                    n_ext = (r_asize > chunk_eff) ? r_asize : chunk_eff;
                    n_state = S_G0;
                end else begin
                    n_bp = 32'd8;
                    mreq.re = 1'b1; mreq.raddr = 32'd4;
                    n_state = S_F1;
                end
            end
            S_F1: begin
                if (sz_rd == 32'd0 || (rd[0] || r_asize > sz_rd)
                        && walk_nx >= 33'(r_break)) begin
                    n_ext = (r_asize > chunk_eff) ? r_asize : chunk_eff;
                    n_state = S_G0;
                end else if (!rd[0] && r_asize <= sz_rd) begin
                    n_state = S_P0;
                end else begin
                    n_bp = walk_nx[31:0];
                    mreq.re = 1'b1; mreq.raddr = walk_nx[31:0] - 32'd4;
                end
            end
            // placement with optional split
            S_P0: begin
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd4;
                n_state = S_P1;
            end
            S_P1: begin
                n_csz = sz_rd;
                mreq.we = 1'b1; mreq.waddr = r_bp - 32'd4;
                if (sz_rd - r_asize >= MIN_BLOCK) begin
                    mreq.wdata = r_asize | ALLOC_BIT;
                    n_state = S_P2;
                end else begin
                    mreq.wdata = sz_rd | ALLOC_BIT;
                    n_state = S_PN2;
                end
            end
            S_P2: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_asize - 32'd8;
                mreq.wdata = r_asize | ALLOC_BIT;
                n_state = S_P3;
            end
            S_P3: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_asize - 32'd4;
                mreq.wdata = r_csz - r_asize;
                n_state = S_P4;
            end
            S_P4: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_csz - 32'd8;
                mreq.wdata = r_csz - r_asize;
                pl_done = 1'b1;
            end
            S_PN2: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_csz - 32'd8;
                mreq.wdata = r_csz | ALLOC_BIT;
                pl_done = 1'b1;
            end
            // realloc: old size, then release old block
            S_R0: begin
                mreq.re = 1'b1; mreq.raddr = 32'(r_addr) - 32'd4;
                n_state = S_R1;
            end
            S_R1: begin
                n_copy = (32'(r_req) < sz_rd) ? r_req : sz_rd[20:0];
                n_bp = 32'(r_addr);
                n_mrel = 1'b1;
                n_state = S_L0;
            end
            S_L0: begin
                mreq.re = 1'b1; mreq.raddr = r_bp - 32'd4;
                n_state = S_L1;
            end
            S_L1: begin
                n_sz = sz_rd;
                mreq.we = 1'b1; mreq.waddr = r_bp - 32'd4; mreq.wdata = sz_rd;
                n_state = S_L2;
            end
            S_L2: begin
                mreq.we = 1'b1; mreq.waddr = r_bp + r_sz - 32'd8; mreq.wdata = r_sz;
                n_state = S_M0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // merge finished: back to release or grow caller
        if (m_done) begin
            n_bp = m_ret;
            if (r_mrel || r_cmd == CMD_INIT) begin
                n_ok = 1'b1;
                n_state = S_DONE;
            end else begin
                n_state = S_P0;
            end
        end
        // block placed
        if (pl_done) begin
            n_res = r_bp[19:0];
            if (r_cmd == CMD_ALLOC) begin
                n_ok = 1'b1;
                n_state = S_DONE;
            end else begin
                n_state = S_R0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_break  <= '0;
            r_inited <= 1'b0;
            r_mrel   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_break  <= n_break;
            r_inited <= n_inited;
            r_mrel   <= n_mrel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;   r_req <= n_req;     r_addr <= n_addr;
        r_bp <= n_bp;     r_t <= n_t;         r_sz <= n_sz;
        r_psz <= n_psz;   r_sum <= n_sum;     r_csz <= n_csz;
        r_asize <= n_asize; r_ext <= n_ext;   r_pa <= n_pa;
        r_res <= n_res;   r_ok <= n_ok;       r_copy <= n_copy;
    end

    // output register
    assign out_load = (r_state == S_DONE) && (!r_ovalid || out_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ores  <= r_res;
            r_ook   <= r_ok;
            r_ocopy <= r_copy;
        end
    end

    assign out_ch.valid          = r_ovalid;
    assign out_ch.result_address = r_ores;
    assign out_ch.success        = r_ook;
    assign out_ch.copy_length    = r_ocopy;

`ifndef SYNTHESIS
    // sequencer never reads and writes the heap in one cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mreq.we && mreq.re))
        else $error("heap read and write in same cycle");

    a_break_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_break) <= 32'(HEAP_BYTES))
        else $error("break past heap end");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> r_state != S_IDLE)
        else $error("command accepted but sequencer idle");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_ovalid && !out_ch.ready |=> r_state == S_DONE)
        else $error("result dropped while output stalled");
`endif

endmodule

### tb/sv/implicit_list_heap_allocator_test.sv
// Self-checking testbench for the first-fit implicit free list heap allocator.
module implicit_list_heap_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hla_pkg::*;

    localparam int unsigned HEAP_SZ   = 1048576;
    localparam int unsigned HEAP_WDS  = HEAP_SZ / 4;
    localparam int unsigned CYC_LIMIT = 3000000;
    localparam int          N_RANDOM  = 600;

    // one result item as the block reports it
    typedef struct packed {
        logic [19:0] addr;
        logic        ok;
        logic [20:0] copy;
    } t_alloc_result;

    // holds predicted result items in order and compares arrivals against them
    class alloc_scoreboard;
        t_alloc_result expected_q[$];
        int            errors;
        int            checked;

        function void note(t_alloc_result r);
            expected_q.push_back(r);
        endfunction

        function void check(t_alloc_result act);
            t_alloc_result exp_r;
            checked++;
            if (expected_q.size() == 0) begin
                if (errors < 10) $display("unexpected result item: addr=%h ok=%b copy=%h",
                                          act.addr, act.ok, act.copy);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r !== act) begin
                if (errors < 10)
                    $display("mismatch #%0d: exp addr=%h ok=%b copy=%h, got addr=%h ok=%b copy=%h",
                             checked, exp_r.addr, exp_r.ok, exp_r.copy,
                             act.addr, act.ok, act.copy);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    hla_in_if  in_ch();
    hla_out_if out_ch();

    implicit_list_heap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    alloc_scoreboard sb = new();

    // ------------------------------------------------------------------
    // Predictor state: heap words, break, prologue payload offset, chunk.
    // Only words the allocator itself wrote are ever read.
    // ------------------------------------------------------------------
    logic [31:0] heap_mem [0:HEAP_WDS-1];
    logic [31:0] brk_off;
    logic [31:0] prologue_bp;
    logic [20:0] chunk_reg;

    logic [31:0] live_q[$];     // payload offsets of blocks currently allocated
    bit          quiet;         // no idling on either side when set
    int          n_items, n_inits, n_fails, n_reallocs, n_frees;

    function automatic logic [31:0] rd_word(input logic [31:0] a);
        return heap_mem[a[19:2]];
    endfunction

    function automatic void wr_word(input logic [31:0] a, input logic [31:0] v);
        heap_mem[a[19:2]] = v;
    endfunction

    function automatic logic [31:0] size_of(input logic [31:0] a);
        return rd_word(a) & SIZE_MASK;
    endfunction

    function automatic logic is_used(input logic [31:0] a);
        return rd_word(a)[0];
    endfunction

    function automatic logic [31:0] next_bp(input logic [31:0] bp);
        return bp + size_of(bp - 32'd4);
    endfunction

    function automatic logic [31:0] prev_bp(input logic [31:0] bp);
        return bp - size_of(bp - 32'd8);
    endfunction

    function automatic logic [31:0] footer_of(input logic [31:0] bp);
        return bp + size_of(bp - 32'd4) - 32'd8;
    endfunction

    // join a free block with free neighbors, all four cases
    function automatic logic [31:0] coalesce(input logic [31:0] bp);
        logic        p_used, n_used;
        logic [31:0] sz;
        p_used = is_used(footer_of(prev_bp(bp)));
        n_used = is_used(next_bp(bp) - 32'd4);
        sz     = size_of(bp - 32'd4);
        if (p_used && n_used) return bp;
        if (p_used) begin
            sz += size_of(next_bp(bp) - 32'd4);
            wr_word(bp - 32'd4, sz);
            wr_word(footer_of(bp), sz);
        end else if (n_used) begin
            sz += size_of(prev_bp(bp) - 32'd4);
            wr_word(footer_of(bp), sz);
            wr_word(prev_bp(bp) - 32'd4, sz);
            bp = prev_bp(bp);
        end else begin
            sz += size_of(prev_bp(bp) - 32'd4) + size_of(footer_of(next_bp(bp)));
            wr_word(prev_bp(bp) - 32'd4, sz);
            wr_word(footer_of(next_bp(bp)), sz);
            bp = prev_bp(bp);
        end
        return bp;
    endfunction

    function automatic bit grow_heap(input logic [31:0] bytes, output logic [31:0] bp);
        if (longint'(brk_off) + longint'(bytes) > longint'(HEAP_SZ)) return 1'b0;
        bp = brk_off;
        brk_off += bytes;
        wr_word(bp - 32'd4, bytes);
        wr_word(footer_of(bp), bytes);
        wr_word(next_bp(bp) - 32'd4, ALLOC_BIT);
        bp = coalesce(bp);
        return 1'b1;
    endfunction

    function automatic logic [31:0] growth_step();
        logic [31:0] c;
        c = (32'(chunk_reg) + 32'd7) & SIZE_MASK;
        return (c == 0) ? 32'd8 : c;
    endfunction

    function automatic bit scan_free(input logic [31:0] asize, output logic [31:0] bp);
        longint unsigned p;
        logic [31:0]     sz;
        p = prologue_bp;
        while (p < longint'(brk_off)) begin
            sz = size_of(32'(p) - 32'd4);
            if (sz == 0) return 1'b0;
            if (!is_used(32'(p) - 32'd4) && asize <= sz) begin
                bp = 32'(p);
                return 1'b1;
            end
            p += sz;
        end
        return 1'b0;
    endfunction

    function automatic void place_block(input logic [31:0] bp, input logic [31:0] asize);
        logic [31:0] csize;
        csize = size_of(bp - 32'd4);
        if (csize - asize >= MIN_BLOCK) begin
            wr_word(bp - 32'd4, asize | ALLOC_BIT);
            wr_word(footer_of(bp), asize | ALLOC_BIT);
            bp = next_bp(bp);
            wr_word(bp - 32'd4, csize - asize);
            wr_word(footer_of(bp), csize - asize);
        end else begin
            wr_word(bp - 32'd4, csize | ALLOC_BIT);
            wr_word(footer_of(bp), csize | ALLOC_BIT);
        end
    endfunction

    function automatic bit carve(input logic [31:0] req, output logic [31:0] bp);
        logic [31:0] asize, ext;
        if (req == 0) return 1'b0;
        asize = (req <= 8) ? MIN_BLOCK : 32'd8 * ((req + 32'd15) / 32'd8);
        if (!scan_free(asize, bp)) begin
            ext = growth_step();
            if (asize > ext) ext = asize;
            if (!grow_heap(ext, bp)) return 1'b0;
        end
        place_block(bp, asize);
        return 1'b1;
    endfunction

    function automatic void release_block(input logic [31:0] bp);
        logic [31:0] sz;
        sz = size_of(bp - 32'd4);
        wr_word(bp - 32'd4, sz);
        wr_word(footer_of(bp), sz);
        void'(coalesce(bp));
    endfunction

    // expected result of one command item; also updates the live block list
    function automatic t_alloc_result heap_outcome(input logic [1:0] cmd,
                                                   input logic [20:0] req,
                                                   input logic [19:0] baddr);
        t_alloc_result r;
        logic [31:0]   bp, old_sz, a;
        r = '0;
        a = 32'(baddr);
        if (cmd == CMD_INIT) begin
            brk_off = 32'd16;
            wr_word(32'd0, 32'd0);
            wr_word(32'd4, 32'd8 | ALLOC_BIT);
            wr_word(32'd8, 32'd8 | ALLOC_BIT);
            wr_word(32'd12, ALLOC_BIT);
            prologue_bp = 32'd8;
            r.ok = grow_heap(growth_step(), bp);
            live_q.delete();
        end else if (prologue_bp != 0) begin
            if (cmd == CMD_ALLOC) begin
                if (carve(32'(req), bp)) begin
                    r.addr = bp[19:0];
                    r.ok   = 1'b1;
                    live_q.push_back(bp);
                end
            end else if (cmd == CMD_FREE) begin
                release_block(a);
                r.ok = 1'b1;
                foreach (live_q[i]) if (live_q[i] == {a[31:2], 2'b00}) begin
                    live_q.delete(i);
                    break;
                end
            end else begin
                if (carve(32'(req), bp)) begin
                    old_sz = size_of(a - 32'd4);
                    r.copy = (32'(req) < old_sz) ? req : old_sz[20:0];
                    release_block(a);
                    r.addr = bp[19:0];
                    r.ok   = 1'b1;
                    foreach (live_q[i]) if (live_q[i] == {a[31:2], 2'b00}) begin
                        live_q.delete(i);
                        break;
                    end
                    live_q.push_back(bp);
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // APB write: setup cycle, access cycle; pready is always high
    task automatic write_chunk(input logic [20:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        chunk_reg = value;
    endtask

    // send one command item, predict its result at acceptance
    task automatic send_cmd(input logic [1:0] cmd, input logic [20:0] req,
                            input logic [19:0] baddr);
        t_alloc_result r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.request_bytes <= req;
        in_ch.block_address <= baddr;
        do @(posedge i_clk); while (!in_ch.ready);
        r = heap_outcome(cmd, req, baddr);
        sb.note(r);
        n_items++;
        if (cmd == CMD_INIT) n_inits++;
        if (cmd == CMD_FREE) n_frees++;
        if (cmd == CMD_REALLOC) n_reallocs++;
        if (!r.ok) n_fails++;
    endtask

    // drain all outstanding results before a register write
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [20:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)  return 21'd0;
        if (roll < 70) return 21'($urandom_range(1, 64));
        if (roll < 92) return 21'($urandom_range(65, 600));
        if (roll < 98) return 21'($urandom_range(601, 9000));
        return 21'($urandom);   // often too large, exhausts the heap
    endfunction

    // a live block to free or move; low address bits are noise the block ignores
    function automatic logic [19:0] pick_live();
        logic [31:0] a;
        a = live_q[$urandom_range(0, live_q.size() - 1)];
        return a[19:0] | 20'($urandom_range(0, 3));
    endfunction

    task automatic random_cmd();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 2 || live_q.size() > 120)
            send_cmd(CMD_INIT, 21'($urandom), 20'($urandom));
        else if (roll < 50 || live_q.size() == 0)
            send_cmd(CMD_ALLOC, pick_size(), 20'($urandom));
        else if (roll < 80)
            send_cmd(CMD_FREE, 21'($urandom), pick_live());
        else
            send_cmd(CMD_REALLOC, pick_size(), pick_live());
    endtask

    // result side: random stall bursts, check every accepted result item
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check('{out_ch.result_address, out_ch.success, out_ch.copy_length});
            if (stall > 0) stall--;
            else if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 15);
            out_ch.ready <= (stall == 0);
        end
    end

    // watchdog
    initial begin
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > CYC_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cyc, sb.expected_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [20:0] chunk_set [6];
        chunk_set = '{21'd4096, 21'd0, 21'd13, 21'd64, 21'd1048576, 21'd2000};
        quiet = 1'b0;
        n_items = 0; n_inits = 0; n_fails = 0; n_reallocs = 0; n_frees = 0;
        brk_off = 0; prologue_bp = 0; chunk_reg = CHUNK_RESET;

        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= 3'd0;
        pwdata              <= 32'd0;
        in_ch.valid         <= 1'b0;
        in_ch.command       <= CMD_INIT;
        in_ch.request_bytes <= '0;
        in_ch.block_address <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // before init nothing happens and every command fails
        send_cmd(CMD_ALLOC, 21'd16, 20'd0);
        send_cmd(CMD_FREE, 21'd0, 20'd8);
        send_cmd(CMD_REALLOC, 21'd32, 20'd24);
        // init with reset chunk, then small blocks and three merge cases
        send_cmd(CMD_INIT, 21'h1FFFFF, 20'hFFFFF);
        send_cmd(CMD_ALLOC, 21'd0, 20'd0);          // zero request
        send_cmd(CMD_ALLOC, 21'd1, 20'd0);
        send_cmd(CMD_ALLOC, 21'd8, 20'd0);
        send_cmd(CMD_ALLOC, 21'd9, 20'd0);
        send_cmd(CMD_ALLOC, 21'd100, 20'd0);
        send_cmd(CMD_ALLOC, 21'd5000, 20'd0);       // grows past the chunk
        send_cmd(CMD_FREE, 21'd0, 20'(live_q[1]));  // both neighbors used
        send_cmd(CMD_FREE, 21'd0, 20'(live_q[1]) | 20'd3); // left neighbor free
        send_cmd(CMD_FREE, 21'd0, 20'(live_q[0]));  // right neighbor free
        send_cmd(CMD_REALLOC, 21'd40, 20'(live_q[0]));
        send_cmd(CMD_REALLOC, 21'd0, 20'(live_q[0]));       // zero request
        send_cmd(CMD_REALLOC, 21'h100000, 20'(live_q[0]));  // heap exhausted
        send_cmd(CMD_ALLOC, 21'h100000, 20'd0);             // heap exhausted
        send_cmd(CMD_ALLOC, 21'h0FFFF0, 20'd0);
        send_cmd(CMD_INIT, 21'd0, 20'd0);                   // repeated init
        settle();
        write_chunk(21'd1048576);                           // init growth fails
        send_cmd(CMD_INIT, 21'd0, 20'd0);
        send_cmd(CMD_ALLOC, 21'd24, 20'd0);
        settle();
        write_chunk(21'd0);                                 // chunk of zero
        send_cmd(CMD_INIT, 21'd0, 20'd0);
        send_cmd(CMD_ALLOC, 21'd4, 20'd0);
        send_cmd(CMD_ALLOC, 21'd4, 20'd0);

        // random phases, one chunk setting each; last phase runs without idling
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_chunk(ph == 5 ? 21'($urandom) : chunk_set[ph]);
            if (ph == 5) quiet = 1'b1;
            send_cmd(CMD_INIT, 21'($urandom), 20'($urandom));
            for (int k = 0; k < N_RANDOM / 6; k++) random_cmd();
        end
        in_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("ran %0d command items (%0d inits, %0d frees, %0d reallocs, %0d failed)",
                 n_items, n_inits, n_frees, n_reallocs, n_fails);
        $display("checked %0d result items, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
